### rtl/farrc_pkg.sv
// shared constants and types for the fully associative round-robin cache
// no dependencies
package farrc_pkg;

    localparam int DEF_NUM_LINES = 16;
    localparam int WORD_W        = 32;
    localparam int OFFSET_W      = 2;
    localparam int TAG_W         = WORD_W - OFFSET_W;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [TAG_W-1:0]  tag_t;

    // one request held in the input register
    typedef struct packed {
        logic  req_type;
        tag_t  tag;
        word_t write_data;
        word_t memory_word;
    } req_t;

endpackage

### rtl/fully_assoc_round_robin_cache_top.sv
// fully associative cache, one-word lines, round-robin fill, write-through
// depends on farrc_pkg
//
//  channel | ports                                             | direction
//  --------+---------------------------------------------------+----------
//  request | s_valid s_ready s_req_type s_address              | in
//          | s_write_data s_memory_word                        |
//  result  | m_valid m_ready m_read_data m_hit m_mem_fetch     | out
//          | m_mem_write                                       |
//
// one item per cycle while the result is not stalled: an item is held in the
// input register, where all line tags are compared in parallel, then moves to
// the result register, which drives m_valid, once the result register is free.
// reset clears all line valid bits, the fill pointer and both valid flags.
// a stalled result holds the input register; new items are taken as soon as
// the input register moves on.
module fully_assoc_round_robin_cache_top #(
    parameter int NUM_LINES = farrc_pkg::DEF_NUM_LINES
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_req_type,
    input  logic [farrc_pkg::WORD_W-1:0] s_address,
    input  logic [farrc_pkg::WORD_W-1:0] s_write_data,
    input  logic [farrc_pkg::WORD_W-1:0] s_memory_word,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [farrc_pkg::WORD_W-1:0] m_read_data,
    output logic                     m_hit,
    output logic                     m_mem_fetch,
    output logic                     m_mem_write
);
    import farrc_pkg::*;

    localparam int PTR_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam logic [PTR_W-1:0] LAST_LINE = PTR_W'(NUM_LINES - 1);

    // input register
    logic in_valid_reg;
    req_t req_reg;

    // line store
    tag_t                 line_tag_reg  [NUM_LINES];
    word_t                line_data_reg [NUM_LINES];
    logic [NUM_LINES-1:0] line_valid_reg;
    logic [PTR_W-1:0]     fill_ptr_reg;

    // result register
    logic  out_valid_reg;
    word_t out_data_reg;
    logic  out_hit_reg;
    logic  out_fetch_reg;
    logic  out_write_reg;

    logic                 advance;
    logic [NUM_LINES-1:0] match;
    logic                 hit;
    word_t                hit_data;
    logic                 do_fill;
    logic                 do_update;
    word_t                out_data_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // parallel tag compare; a tag is only ever in one valid line
    always_comb begin
        hit_data = '0;
        for (int i = 0; i < NUM_LINES; i++) begin
            match[i] = line_valid_reg[i] && (line_tag_reg[i] == req_reg.tag);
            hit_data = hit_data | (line_data_reg[i] & {WORD_W{match[i]}});
        end
    end

    assign hit       = |match;
    assign do_fill   = advance && (req_reg.req_type == REQ_READ) && !hit;
    assign do_update = advance && (req_reg.req_type == REQ_WRITE) && hit;

    always_comb begin
        if (req_reg.req_type == REQ_WRITE) begin
            out_data_next = '0;
        end else if (hit) begin
            out_data_next = hit_data;
        end else begin
            out_data_next = req_reg.memory_word;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            line_valid_reg <= '0;
            fill_ptr_reg   <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (do_fill) begin
                line_valid_reg[fill_ptr_reg] <= 1'b1;
                fill_ptr_reg <= (fill_ptr_reg == LAST_LINE) ? '0 : fill_ptr_reg + PTR_W'(1);
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg.req_type    <= s_req_type;
            req_reg.tag         <= s_address[WORD_W-1:OFFSET_W];
            req_reg.write_data  <= s_write_data;
            req_reg.memory_word <= s_memory_word;
        end
        if (advance) begin
            out_data_reg  <= out_data_next;
            out_hit_reg   <= hit;
            out_fetch_reg <= do_fill;
            out_write_reg <= (req_reg.req_type == REQ_WRITE);
        end
        for (int i = 0; i < NUM_LINES; i++) begin
            if (do_fill && (fill_ptr_reg == PTR_W'(i))) begin
                line_tag_reg[i]  <= req_reg.tag;
                line_data_reg[i] <= req_reg.memory_word;
            end else if (do_update && match[i]) begin
                line_data_reg[i] <= req_reg.write_data;
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_read_data = out_data_reg;
    assign m_hit       = out_hit_reg;
    assign m_mem_fetch = out_fetch_reg;
    assign m_mem_write = out_write_reg;

endmodule

### verif/fully_assoc_round_robin_cache_top_tb.sv
// testbench for fully_assoc_round_robin_cache_top: directed and random accesses,
// checked against a cycle-free cache predictor held in the bench
// depends on farrc_pkg and the cache top level
module fully_assoc_round_robin_cache_top_tb;

    import farrc_pkg::*;

    localparam int NUM_LINES   = DEF_NUM_LINES;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        word_t read_data;
        logic  hit;
        logic  mem_fetch;
        logic  mem_write;
    } access_result_t;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    logic  s_req_type;
    word_t s_address;
    word_t s_write_data;
    word_t s_memory_word;
    logic  m_valid;
    logic  m_ready;
    word_t m_read_data;
    logic  m_hit;
    logic  m_mem_fetch;
    logic  m_mem_write;

    // predicted cache contents
    tag_t  model_tag [NUM_LINES];
    logic  model_valid [NUM_LINES];
    word_t model_data [NUM_LINES];
    int    model_fill_ptr;

    access_result_t pending_results[$];
    int error_count;
    int sender_idle_pct;
    int receiver_idle_pct;

    fully_assoc_round_robin_cache_top #(
        .NUM_LINES(NUM_LINES)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_address    (s_address),
        .s_write_data (s_write_data),
        .s_memory_word(s_memory_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_hit        (m_hit),
        .m_mem_fetch  (m_mem_fetch),
        .m_mem_write  (m_mem_write)
    );

    always #5 aclk = ~aclk;

    // updates the predicted contents and returns the result of one access
    function automatic access_result_t predict_access(input logic req, input word_t addr,
                                                      input word_t wdata, input word_t mword);
        access_result_t res;
        tag_t tag;
        int match;
        tag = addr[WORD_W-1:OFFSET_W];
        match = -1;
        res = '0;
        // scan downward so the lowest matching line wins
        for (int i = NUM_LINES - 1; i >= 0; i--) begin
            if (model_valid[i] && model_tag[i] == tag) match = i;
        end
        res.hit = (match >= 0);
        if (req == REQ_WRITE) begin
            if (match >= 0) model_data[match] = wdata;
            res.mem_write = 1'b1;
        end else if (match >= 0) begin
            res.read_data = model_data[match];
        end else begin
            model_tag[model_fill_ptr]   = tag;
            model_data[model_fill_ptr]  = mword;
            model_valid[model_fill_ptr] = 1'b1;
            model_fill_ptr = (model_fill_ptr + 1) % NUM_LINES;
            res.read_data = mword;
            res.mem_fetch = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input word_t want, input word_t got);
        $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
        error_count++;
    endtask

    // predict on every accepted item, check every accepted result
    always @(posedge aclk) begin
        access_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, read_data", '0, m_read_data);
                end else begin
                    want = pending_results.pop_front();
                    if (m_read_data !== want.read_data)
                        report_mismatch("read_data", want.read_data, m_read_data);
                    if (m_hit !== want.hit)
                        report_mismatch("hit", word_t'(want.hit), word_t'(m_hit));
                    if (m_mem_fetch !== want.mem_fetch)
                        report_mismatch("mem_fetch", word_t'(want.mem_fetch),
                                        word_t'(m_mem_fetch));
                    if (m_mem_write !== want.mem_write)
                        report_mismatch("mem_write", word_t'(want.mem_write),
                                        word_t'(m_mem_write));
                end
            end
            if (s_valid && s_ready)
                pending_results.push_back(predict_access(s_req_type, s_address,
                                                         s_write_data, s_memory_word));
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("TEST FAILED");
        $finish;
    end

    // entered and left at a falling edge
    task automatic send_access(input logic req, input word_t addr,
                               input word_t wdata, input word_t mword);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_address     <= addr;
        s_write_data  <= wdata;
        s_memory_word <= mword;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_until_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    task automatic test_hits_writes_extremes();
        send_access(REQ_READ,  32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // same tag with other offset bits
        send_access(REQ_READ,  32'h0000_0003, 32'hFFFF_FFFF, 32'h0000_0000);
        send_access(REQ_WRITE, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF);
        send_access(REQ_READ,  32'h0000_0000, 32'h1234_5678, 32'h8765_4321);
        // write miss leaves the cache alone
        send_access(REQ_WRITE, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h0000_0000);
        send_access(REQ_READ,  32'hFFFF_FFFC, 32'h0000_0000, 32'h5A5A_5A5A);
        send_access(REQ_WRITE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    // more fills than lines: the pointer wraps and the oldest lines go
    task automatic test_round_robin_eviction();
        for (int i = 0; i <= NUM_LINES; i++)
            send_access(REQ_READ, 32'h4000_0000 + 4 * i, $urandom, $urandom);
        send_access(REQ_READ, 32'h4000_0000, $urandom, $urandom);
    endtask

    // mostly a small working set of tags around the line count, some stray addresses
    task automatic test_random_traffic(input int count);
        tag_t hot_tags [24];
        int   hot_count;
        tag_t tag;
        logic req;
        hot_count = $urandom_range(6, 24);
        foreach (hot_tags[i]) hot_tags[i] = tag_t'($urandom);
        repeat (count) begin
            if ($urandom_range(99) < 85)
                tag = hot_tags[$urandom_range(hot_count - 1)];
            else
                tag = tag_t'($urandom);
            req = ($urandom_range(99) < 40) ? REQ_WRITE : REQ_READ;
            send_access(req, {tag, OFFSET_W'($urandom)}, $urandom, $urandom);
        end
    endtask

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_req_type    = REQ_READ;
        s_address     = '0;
        s_write_data  = '0;
        s_memory_word = '0;
        m_ready       = 1'b0;
        error_count   = 0;
        model_fill_ptr = 0;
        foreach (model_valid[i]) model_valid[i] = 1'b0;
        sender_idle_pct   = 8;
        receiver_idle_pct = 66;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_hits_writes_extremes();
        test_round_robin_eviction();
        test_random_traffic(160);
        wait_until_drained();

        sender_idle_pct   = 66;
        receiver_idle_pct = 8;
        test_random_traffic(160);
        wait_until_drained();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_traffic(160);
        wait_until_drained();
        repeat (4) @(negedge aclk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
